/* src/two_level_page_table_engine_top_macros.svh */
// assertion macros for the page table engine
`ifndef TWO_LEVEL_PAGE_TABLE_ENGINE_TOP_MACROS_SVH
`define TWO_LEVEL_PAGE_TABLE_ENGINE_TOP_MACROS_SVH

// check on every clock edge outside reset
`define TLPTE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check on every clock edge, reset included
`define TLPTE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* src/tlpte_pkg.sv */
// types and constants of the two-level page table engine
package tlpte_pkg;

    // table pool and geometry
    localparam int NUM_TABLES    = 64;
    localparam int DIR_ENTRIES   = 1024;
    localparam int TBL_ENTRIES   = 1024;
    localparam int IDX_W         = 10;
    localparam int FLAG_W        = 12;
    localparam int DIR_SHIFT     = 22;
    localparam int TBL_SHIFT     = 12;
    localparam int TBL_W         = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int NFT_W         = $clog2(NUM_TABLES + 1);
    localparam int DIR_W         = TBL_W + FLAG_W;
    localparam int STORE_DEPTH   = NUM_TABLES * TBL_ENTRIES;
    localparam int STORE_AW      = TBL_W + IDX_W;

    // operation codes
    typedef enum logic [1:0] {
        OP_MAP       = 2'd0,
        OP_UNMAP     = 2'd1,
        OP_TRANSLATE = 2'd2,
        OP_NONE      = 2'd3
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NOT_MAPPED = 2'd1,
        ST_NO_TABLE   = 2'd2
    } t_status;

    // walk sequencer states
    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_DIR   = 2'd2,
        S_TBL   = 2'd3
    } t_state;

endpackage

/* src/two_level_page_table_engine_top.sv */
// top level of the two-level page table engine
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one word: an operation
//   (map, unmap, translate, none) on a 32-bit virtual address with its
//   physical address and flags. Output channel (o_out_valid / i_out_ready)
//   gives one word per input word: status, result address, released flag.
//   Directory and second-level tables live in two synchronous memories with
//   registered reads. Map, none, and any miss in the directory load the
//   result register from S_DIR (directory read, then for map the table
//   write unless the pool is empty); unmap and translate that hit load it
//   from S_TBL (directory read, table read, then for unmap a table
//   write-back). The next word is taken in S_IDLE once the result is
//   loaded and the output register is free or being read; never mid walk.
//   After reset the block sweeps both memories to zero, one table entry per
//   cycle, NUM_TABLES * 1024 entries in all, while o_in_ready is low; the
//   directory is cleared along with the first 1024 table entries.
//   The result sits in an output register; while it is stalled by
//   i_out_ready low, no new word is accepted, and the block never drops
//   or overwrites a result.
`include "two_level_page_table_engine_top_macros.svh"

module two_level_page_table_engine_top
    import tlpte_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_virt_addr,
    input  logic [31:0] i_phys_addr,
    input  logic [11:0] i_page_flags,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_result_addr,
    output logic        o_frame_released
);

    // memories
    logic [DIR_W-1:0] directory [0:DIR_ENTRIES-1];
    logic [31:0]      table_store [0:STORE_DEPTH-1];

    // control state
    t_state               r_state, n_state;
    logic [STORE_AW-1:0]  r_clr_cnt;
    logic [NFT_W-1:0]     r_nft, n_nft;

    // captured word
    t_op                  r_op;
    logic [31:0]          r_va;
    logic [31:0]          r_pa;
    logic [FLAG_W-1:0]    r_fl;

    // memory read data
    logic [DIR_W-1:0]     r_dir_q;
    logic [31:0]          r_st_q;

    // output register
    logic                 r_out_valid;
    t_status              r_status;
    logic [31:0]          r_addr;
    logic                 r_rel;

    // combinational control
    logic                 in_accept;
    logic                 de_present;
    logic [TBL_W-1:0]     de_tbl;
    logic [IDX_W-1:0]     tbl_idx;
    logic [IDX_W-1:0]     dir_idx;
    logic [FLAG_W-1:0]    fl_present;
    logic                 pool_empty;
    logic                 dir_walk;
    logic                 dir_we;
    logic [IDX_W-1:0]     dir_wa;
    logic [DIR_W-1:0]     dir_wd;
    logic                 st_we;
    logic [STORE_AW-1:0]  st_wa;
    logic [31:0]          st_wd;
    logic [STORE_AW-1:0]  st_ra;
    logic                 load_out;
    t_status              n_status;
    logic [31:0]          n_addr;
    logic                 n_rel;

    // handshake
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_accept  = i_in_valid && o_in_ready;

    // fields of the walk
    assign de_present = r_dir_q[0];
    assign de_tbl     = r_dir_q[DIR_W-1:FLAG_W];
    assign tbl_idx    = r_va[TBL_SHIFT +: IDX_W];
    assign dir_idx    = r_va[DIR_SHIFT +: IDX_W];
    assign fl_present = {r_fl[FLAG_W-1:1], 1'b1};
    assign pool_empty = (r_nft == NFT_W'(NUM_TABLES));
    assign st_ra      = {de_tbl, tbl_idx};
    assign dir_walk   = ((r_op == OP_UNMAP) || (r_op == OP_TRANSLATE)) && de_present;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_cnt == STORE_AW'(STORE_DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_accept) n_state = S_DIR;
            end
            S_DIR: begin
                n_state = dir_walk ? S_TBL : S_IDLE;
            end
            S_TBL: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // memory writes, pool counter and result
    always_comb begin
        dir_we   = 1'b0;
        dir_wa   = dir_idx;
        dir_wd   = {TBL_W'(r_nft), fl_present};
        st_we    = 1'b0;
        st_wa    = st_ra;
        st_wd    = {r_pa[31:TBL_SHIFT], fl_present};
        n_nft    = r_nft;
        load_out = 1'b0;
        n_status = ST_OK;
        n_addr   = 32'd0;
        n_rel    = 1'b0;
        case (r_state)
            S_CLEAR: begin
                st_we  = 1'b1;
                st_wa  = r_clr_cnt;
                st_wd  = 32'd0;
                dir_we = (r_clr_cnt < STORE_AW'(DIR_ENTRIES));
                dir_wa = r_clr_cnt[IDX_W-1:0];
                dir_wd = '0;
            end
            S_DIR: begin
                case (r_op)
                    OP_MAP: begin
                        load_out = 1'b1;
                        if (de_present) begin
                            st_we = 1'b1;
                        end else if (pool_empty) begin
                            n_status = ST_NO_TABLE;
                        end else begin
                            // new table from the pool, its entries already zero
                            dir_we = 1'b1;
                            st_we  = 1'b1;
                            st_wa  = {TBL_W'(r_nft), tbl_idx};
                            n_nft  = r_nft + NFT_W'(1);
                        end
                    end
                    OP_UNMAP, OP_TRANSLATE: begin
                        if (!de_present) begin
                            load_out = 1'b1;
                            n_status = ST_NOT_MAPPED;
                        end
                    end
                    default: begin
                        load_out = 1'b1;
                    end
                endcase
            end
            S_TBL: begin
                load_out = 1'b1;
                if (!r_st_q[0]) begin
                    n_status = ST_NOT_MAPPED;
                end else if (r_op == OP_UNMAP) begin
                    st_we  = 1'b1;
                    st_wd  = 32'd0;
                    n_addr = {r_st_q[31:TBL_SHIFT], 12'd0};
                    n_rel  = 1'b1;
                end else begin
                    n_addr = {r_st_q[31:TBL_SHIFT], r_va[TBL_SHIFT-1:0]};
                end
            end
            default: begin
                load_out = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_cnt <= '0;
            r_nft     <= '0;
        end else begin
            r_state <= n_state;
            r_nft   <= n_nft;
            if (r_state == S_CLEAR) r_clr_cnt <= r_clr_cnt + STORE_AW'(1);
        end
    end

    // captured word
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op <= t_op'(i_operation);
            r_va <= i_virt_addr;
            r_pa <= i_phys_addr;
            r_fl <= i_page_flags;
        end
    end

    // page directory memory
    always_ff @(posedge i_clk) begin
        if (dir_we) directory[dir_wa] <= dir_wd;
        if (in_accept) r_dir_q <= directory[i_virt_addr[DIR_SHIFT +: IDX_W]];
    end

    // second-level table memory
    always_ff @(posedge i_clk) begin
        if (st_we) table_store[st_wa] <= st_wd;
        r_st_q <= table_store[st_ra];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_status <= n_status;
            r_addr   <= n_addr;
            r_rel    <= n_rel;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_result_addr    = r_addr;
    assign o_frame_released = r_rel;

    // checks
    `TLPTE_ASSERT(a_pool_bound, r_nft <= NFT_W'(NUM_TABLES), "table pool counter overran")
    `TLPTE_ASSERT(a_ready_idle, o_in_ready |-> (r_state == S_IDLE), "word taken mid walk")
    `TLPTE_ASSERT(a_no_overwrite, load_out |-> (!r_out_valid || i_out_ready), "result overwritten")
    `TLPTE_ASSERT(a_rel_ok, (o_out_valid && o_frame_released) |-> (o_status == ST_OK), "bad release")
    `TLPTE_ASSERT(a_nft_on_map, (r_nft != $past(r_nft)) |-> $past(r_state == S_DIR && r_op == OP_MAP), "pool moved outside map")
    `TLPTE_ASSERT_ALWAYS(a_clear_quiet, (r_state == S_CLEAR) |-> !o_in_ready, "word taken in clear")

endmodule

/* tb/two_level_page_table_engine_top_tb.sv */
// self-checking testbench for the two-level page table engine
`timescale 1ns / 100ps

module two_level_page_table_engine_top_tb;
    import tlpte_pkg::*;

    localparam int RANDOM_WORDS = 1500;
    localparam int FINAL_WORDS  = 80;
    localparam int SWEEP_WORDS  = 70;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOT_DIRS     = 48;
    localparam int HOT_SLOTS    = 16;

    // one expected result word
    typedef struct packed {
        t_status     status;
        logic [31:0] addr;
        logic        released;
    } t_answer;

    // one row of the directed stimulus; the answer is only used when has_want is set
    typedef struct packed {
        t_op         op;
        logic [31:0] va;
        logic [31:0] pa;
        logic [11:0] fl;
        logic        has_want;
        t_status     st;
        logic [31:0] ra;
        logic        rel;
    } t_stim_row;

    localparam t_stim_row DIRECTED_ROWS [0:19] = '{
        '{OP_TRANSLATE, 32'h0000_0000, 32'h0000_0000, 12'h000, 1'b1, ST_NOT_MAPPED, 32'h0, 1'b0},
        '{OP_UNMAP,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF, 1'b1, ST_NOT_MAPPED, 32'h0, 1'b0},
        '{OP_NONE,      32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF, 1'b1, ST_OK, 32'h0, 1'b0},
        '{OP_MAP,       32'h0000_0000, 32'hFFFF_FFFF, 12'h000, 1'b1, ST_OK, 32'h0, 1'b0},
        '{OP_TRANSLATE, 32'h0000_0FFF, 32'h0000_0000, 12'h000, 1'b1, ST_OK, 32'hFFFF_FFFF, 1'b0},
        '{OP_MAP,       32'hFFFF_FFFF, 32'h0000_0000, 12'hFFF, 1'b1, ST_OK, 32'h0, 1'b0},
        '{OP_TRANSLATE, 32'hFFFF_F000, 32'h0000_0000, 12'h000, 1'b1, ST_OK, 32'h0, 1'b0},
        '{OP_UNMAP,     32'hFFFF_FABC, 32'h0000_0000, 12'h000, 1'b1, ST_OK, 32'h0, 1'b1},
        '{OP_UNMAP,     32'hFFFF_FABC, 32'h0000_0000, 12'h000, 1'b1, ST_NOT_MAPPED, 32'h0, 1'b0},
        '{OP_TRANSLATE, 32'hFFFF_F000, 32'h0000_0000, 12'h000, 1'b1, ST_NOT_MAPPED, 32'h0, 1'b0},
        '{OP_MAP,       32'h0040_0123, 32'h1234_5678, 12'h0FE, 1'b0, ST_OK, 32'h0, 1'b0},
        '{OP_TRANSLATE, 32'h0040_0ABC, 32'h0000_0000, 12'h000, 1'b0, ST_OK, 32'h0, 1'b0},
        '{OP_MAP,       32'h0040_1000, 32'hABCD_E000, 12'h001, 1'b0, ST_OK, 32'h0, 1'b0},
        '{OP_MAP,       32'h0040_0000, 32'h5555_5FFF, 12'h800, 1'b0, ST_OK, 32'h0, 1'b0},
        '{OP_TRANSLATE, 32'h0040_0001, 32'h0000_0000, 12'h000, 1'b0, ST_OK, 32'h0, 1'b0},
        '{OP_UNMAP,     32'h0040_1FFF, 32'h0000_0000, 12'h000, 1'b0, ST_OK, 32'h0, 1'b0},
        '{OP_TRANSLATE, 32'h0080_0123, 32'h0000_0000, 12'h000, 1'b1, ST_NOT_MAPPED, 32'h0, 1'b0},
        '{OP_NONE,      32'h0000_0000, 32'h0000_0000, 12'h000, 1'b1, ST_OK, 32'h0, 1'b0},
        '{OP_UNMAP,     32'h0000_0000, 32'h0000_0000, 12'h000, 1'b1, ST_OK, 32'hFFFF_F000, 1'b1},
        '{OP_TRANSLATE, 32'h0000_0000, 32'h0000_0000, 12'h000, 1'b1, ST_NOT_MAPPED, 32'h0, 1'b0}
    };

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_in_valid       = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_operation      = 2'd0;
    logic [31:0] i_virt_addr      = 32'd0;
    logic [31:0] i_phys_addr      = 32'd0;
    logic [11:0] i_page_flags     = 12'd0;
    logic        o_out_valid;
    logic        i_out_ready      = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_result_addr;
    logic        o_frame_released;

    // shadow copy of the walk state
    logic [18:0] shadow_dir [DIR_ENTRIES];
    logic [31:0] shadow_tables [STORE_DEPTH];
    int          tables_used;

    t_answer     pending_answers [$];
    logic [31:0] recent_pages [$];
    logic [9:0]  hot_dirs [HOT_DIRS];
    logic [9:0]  hot_slots [HOT_SLOTS];

    bit idle_on;
    bit hold_req;
    int mismatches;
    int words_sent;
    int results_checked;
    int pool_refusals;
    int frames_released;

    two_level_page_table_engine_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_virt_addr      (i_virt_addr),
        .i_phys_addr      (i_phys_addr),
        .i_page_flags     (i_page_flags),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_result_addr    (o_result_addr),
        .o_frame_released (o_frame_released)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // store index of the entry for an address, -1 when its table is absent
    function automatic int find_slot(logic [31:0] va);
        logic [18:0] de;
        int          tnum;
        de = shadow_dir[va[31:22]];
        if (!de[0]) return -1;
        tnum = int'(de[18:12]);
        if (tnum >= NUM_TABLES) return -1;
        return tnum * TBL_ENTRIES + int'(va[21:12]);
    endfunction

    // expected answer of one word, updating the shadow state
    function automatic t_answer predict_walk(t_op op, logic [31:0] va, logic [31:0] pa,
                                             logic [11:0] fl);
        t_answer     ans;
        int          slot;
        logic [11:0] flp;
        ans = '{ST_OK, 32'h0, 1'b0};
        flp = fl | 12'h001;
        case (op)
            OP_MAP: begin
                slot = find_slot(va);
                if (slot < 0) begin
                    if (tables_used >= NUM_TABLES) begin
                        ans.status = ST_NO_TABLE;
                    end else begin
                        shadow_dir[va[31:22]] = {7'(tables_used), flp};
                        tables_used++;
                        slot = find_slot(va);
                    end
                end
                if (slot >= 0) shadow_tables[slot] = {pa[31:12], flp};
            end
            OP_UNMAP, OP_TRANSLATE: begin
                slot = find_slot(va);
                if (slot < 0 || !shadow_tables[slot][0]) begin
                    ans.status = ST_NOT_MAPPED;
                end else if (op == OP_UNMAP) begin
                    ans.addr = {shadow_tables[slot][31:12], 12'h000};
                    ans.released = 1'b1;
                    shadow_tables[slot] = 32'h0;
                end else begin
                    ans.addr = {shadow_tables[slot][31:12], va[11:0]};
                end
            end
            default: ;
        endcase
        return ans;
    endfunction

    // offer one word, entered at a rising edge, returns at the edge that takes it
    task automatic offer_word(t_op op, logic [31:0] va, logic [31:0] pa, logic [11:0] fl,
                              logic has_want, t_answer want);
        t_answer ans;
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_virt_addr  <= va;
        i_phys_addr  <= pa;
        i_page_flags <= fl;
        do @(negedge i_clk); while (!o_in_ready);
        @(posedge i_clk);
        ans = predict_walk(op, va, pa, fl);
        if (has_want) ans = want;
        if (ans.status == ST_NO_TABLE) pool_refusals++;
        pending_answers.push_back(ans);
        words_sent++;
    endtask

    // random gap on the sending side
    task automatic sender_gap();
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    // page address biased towards a working set of directories and slots
    function automatic logic [31:0] random_page_addr();
        logic [9:0] di;
        logic [9:0] ti;
        di = ($urandom_range(0, 4) != 0) ? hot_dirs[$urandom_range(0, HOT_DIRS - 1)]
                                         : 10'($urandom_range(0, 1023));
        ti = ($urandom_range(0, 4) < 3) ? hot_slots[$urandom_range(0, HOT_SLOTS - 1)]
                                        : 10'($urandom_range(0, 1023));
        return {di, ti, 12'($urandom_range(0, 4095))};
    endfunction

    // one random word: maps build the working set, unmaps and translates mostly hit it
    task automatic random_word();
        int          r;
        t_op         op;
        logic [31:0] va;
        r = $urandom_range(0, 99);
        if (r < 35)      op = OP_MAP;
        else if (r < 55) op = OP_UNMAP;
        else if (r < 95) op = OP_TRANSLATE;
        else             op = OP_NONE;
        if (op == OP_MAP) begin
            va = random_page_addr();
            recent_pages.push_back(va);
            if (recent_pages.size() > 96) void'(recent_pages.pop_front());
        end else if (recent_pages.size() != 0 && $urandom_range(0, 3) != 0) begin
            va = {recent_pages[$urandom_range(0, recent_pages.size() - 1)][31:12],
                  12'($urandom_range(0, 4095))};
        end else begin
            va = $urandom;
        end
        offer_word(op, va, $urandom, 12'($urandom_range(0, 4095)), 1'b0, '0);
    endtask

    // result checker: words seen at the falling edge are taken at the next rising edge
    always @(negedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_answers.size() == 0) begin
                $error("result word with no expectation: status %0d addr %h released %0d",
                       o_status, o_result_addr, o_frame_released);
                mismatches++;
            end else begin
                want = pending_answers.pop_front();
                results_checked++;
                if (o_frame_released) frames_released++;
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatches++;
                end
                if (o_result_addr !== want.addr) begin
                    $error("result_addr: expected %h, got %h", want.addr, o_result_addr);
                    mismatches++;
                end
                if (o_frame_released !== want.released) begin
                    $error("frame_released: expected %0d, got %0d",
                           want.released, o_frame_released);
                    mismatches++;
                end
            end
        end
    end

    // receiving side: random stalls, and one long hold-off on request
    initial begin
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // watchdog, allows for the clearing pass after reset
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // stimulus
    initial begin
        foreach (shadow_dir[k]) shadow_dir[k] = '0;
        foreach (shadow_tables[k]) shadow_tables[k] = '0;
        foreach (hot_dirs[k]) hot_dirs[k] = 10'($urandom_range(0, 1023));
        foreach (hot_slots[k]) hot_slots[k] = 10'($urandom_range(0, 1023));
        tables_used = 0;
        idle_on = 1'b1;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows: empty engine, extremes, remap, release, ignored code
        foreach (DIRECTED_ROWS[k]) begin
            offer_word(DIRECTED_ROWS[k].op, DIRECTED_ROWS[k].va, DIRECTED_ROWS[k].pa,
                       DIRECTED_ROWS[k].fl, DIRECTED_ROWS[k].has_want,
                       '{DIRECTED_ROWS[k].st, DIRECTED_ROWS[k].ra, DIRECTED_ROWS[k].rel});
            sender_gap();
        end

        // random words with stalls on both sides
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == 400) hold_req = 1'b1;
            if (n == 900) begin
                i_in_valid <= 1'b0;
                while (pending_answers.size() != 0) @(posedge i_clk);
            end
            random_word();
            sender_gap();
        end

        // back-to-back tail, then a sweep of fresh directories that drains the pool
        idle_on = 1'b0;
        for (int n = 0; n < FINAL_WORDS; n++) random_word();
        for (int n = 0; n < SWEEP_WORDS; n++) begin
            offer_word(OP_MAP, {10'(1023 - n), 22'($urandom)}, $urandom,
                       12'($urandom_range(0, 4095)), 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("%0d words sent, %0d results checked, %0d frames released",
                 words_sent, results_checked, frames_released);
        $display("%0d of %0d tables handed out, %0d maps refused for an empty pool",
                 tables_used, NUM_TABLES, pool_refusals);
        if (mismatches == 0 && pending_answers.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/tlpte_pkg.sv
src/two_level_page_table_engine_top.sv
tb/two_level_page_table_engine_top_tb.sv
